/* rtl/lsps_pkg.sv */
// Shared types, register codes and the sensor pattern table for the line-sensor
// PID steering core. Depends on nothing; every other file but lsps_fifo uses it.
`default_nettype none

package lsps_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D     = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_LIMIT = 8'd4;

    localparam logic [7:0] RST_BASE_SPEED = 8'd120;
    localparam logic [7:0] RST_GAIN_P     = 8'd12;
    localparam logic [7:0] RST_GAIN_I     = 8'd0;
    localparam logic [7:0] RST_GAIN_D     = 8'd0;
    localparam logic [7:0] RST_TURN_LIMIT = 8'd80;

    localparam int ERR_W   = 5;
    localparam int DELTA_W = 6;
    localparam int TURN_W  = 9;
    localparam int TGT_W   = 10;

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 8;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH) + 1;

    localparam int NUM_PATTERNS = 12;

    localparam logic [7:0] PAT_MASK [NUM_PATTERNS] = '{
        8'hFF, 8'hFF, 8'hC3, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    localparam logic [7:0] PAT_VALUE [NUM_PATTERNS] = '{
        8'h07, 8'hE0, 8'h00, 8'hEF, 8'hCF, 8'h9F,
        8'h7F, 8'hF7, 8'hF3, 8'hF9, 8'hFE, 8'hE7
    };

    localparam logic signed [ERR_W-1:0] PAT_ERR [NUM_PATTERNS] = '{
        -5'sd15, 5'sd15, 5'sd0, -5'sd1, -5'sd2, -5'sd8,
        -5'sd10, 5'sd1, 5'sd2, 5'sd8, 5'sd10, 5'sd0
    };

    typedef struct packed {
        logic [7:0] base_speed;
        logic [7:0] gain_p;
        logic [7:0] gain_i;
        logic [7:0] gain_d;
        logic [7:0] turn_limit;
    } cfg_t;

    // The first matching pattern wins; no match gives an error of zero.
    function automatic logic signed [ERR_W-1:0] decode_error(input logic [7:0] bits);
        logic signed [ERR_W-1:0] err;
        logic                    hit;
        err = '0;
        hit = 1'b0;
        for (int k = 0; k < NUM_PATTERNS; k++)
        begin
            if (!hit && ((bits & PAT_MASK[k]) == PAT_VALUE[k]))
            begin
                err = PAT_ERR[k];
                hit = 1'b1;
            end
        end
        return err;
    endfunction

endpackage

`default_nettype wire

/* rtl/lsps_fifo.sv */
// Small first-in first-out queue built on a register array.
// Used between the front and back halves and at the result side; uses no package.
`default_nettype none

module lsps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           wdata,
    output logic                            full,
    input  wire logic                       pop,
    output logic [WIDTH-1:0]                rdata,
    output logic                            empty,
    output logic [$clog2(DEPTH):0]          count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH) + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* rtl/lsps_front.sv */
// Front half: decodes the sensor pattern and updates the error sum and last error.
// Depends on lsps_pkg for the pattern table and field widths.
`default_nettype none

module lsps_front #(
    parameter int SUM_BITS = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                accept,
    input  wire logic [7:0]                          sensor_bits,
    output logic signed [lsps_pkg::ERR_W-1:0]        err,
    output logic signed [SUM_BITS-1:0]               sum,
    output logic signed [lsps_pkg::DELTA_W-1:0]      delta
);

    import lsps_pkg::*;

    localparam int SW1 = SUM_BITS + 1;

    logic signed [SUM_BITS-1:0] error_sum_reg;
    logic signed [SUM_BITS-1:0] error_sum_next;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [SW1-1:0]      sum_wide;

    assign err      = decode_error(sensor_bits);
    assign sum_wide = SW1'(error_sum_reg) + SW1'(err);
    assign delta    = DELTA_W'(err) - DELTA_W'(prev_err_reg);
    assign sum      = error_sum_next;

    always_comb
    begin
        if (sum_wide[SW1-1] != sum_wide[SW1-2])
        begin
            error_sum_next = sum_wide[SW1-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                             : {1'b0, {(SUM_BITS-1){1'b1}}};
        end
        else
        begin
            error_sum_next = sum_wide[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end
        else if (accept)
        begin
            error_sum_reg <= error_sum_next;
            prev_err_reg  <= err;
        end
    end

endmodule

`default_nettype wire

/* rtl/lsps_back.sv */
// Back half: gain products, their sum, the turn clamp and the wheel targets.
// Depends on lsps_pkg for the configuration struct and field widths.
`default_nettype none

module lsps_back #(
    parameter int SUM_BITS = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lsps_pkg::cfg_t                      cfg,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [lsps_pkg::ERR_W-1:0]   in_err,
    input  wire logic signed [SUM_BITS-1:0]          in_sum,
    input  wire logic signed [lsps_pkg::DELTA_W-1:0] in_delta,
    input  wire logic [lsps_pkg::OUT_CNT_W-1:0]      out_count,
    output logic                                     out_valid,
    output logic signed [lsps_pkg::ERR_W-1:0]        out_err,
    output logic signed [lsps_pkg::TURN_W-1:0]       out_turn,
    output logic signed [lsps_pkg::TGT_W-1:0]        out_left,
    output logic signed [lsps_pkg::TGT_W-1:0]        out_right
);

    import lsps_pkg::*;

    localparam int PP_W  = ERR_W + 9;
    localparam int PI_W  = SUM_BITS + 9;
    localparam int PD_W  = DELTA_W + 9;
    localparam int RAW_W = SUM_BITS + 11;
    localparam int CR_W  = OUT_CNT_W + 1;

    logic                    p_valid_reg;
    logic signed [ERR_W-1:0] p_err_reg;
    logic signed [PP_W-1:0]  prod_p_reg;
    logic signed [PI_W-1:0]  prod_i_reg;
    logic signed [PD_W-1:0]  prod_d_reg;
    logic                    s_valid_reg;
    logic signed [ERR_W-1:0] s_err_reg;
    logic signed [RAW_W-1:0] raw_reg;

    logic signed [8:0]        gp_s;
    logic signed [8:0]        gi_s;
    logic signed [8:0]        gd_s;
    logic signed [PP_W-1:0]   prod_p_next;
    logic signed [PI_W-1:0]   prod_i_next;
    logic signed [PD_W-1:0]   prod_d_next;
    logic signed [RAW_W-1:0]  raw_next;
    logic signed [RAW_W-1:0]  lim_pos;
    logic signed [RAW_W-1:0]  lim_neg;
    logic [CR_W-1:0]          in_flight;

    assign in_flight = CR_W'(out_count) + CR_W'(p_valid_reg) + CR_W'(s_valid_reg);
    assign in_ready  = (in_flight < CR_W'(OUT_DEPTH));

    assign gp_s        = $signed({1'b0, cfg.gain_p});
    assign gi_s        = $signed({1'b0, cfg.gain_i});
    assign gd_s        = $signed({1'b0, cfg.gain_d});
    assign prod_p_next = gp_s * in_err;
    assign prod_i_next = gi_s * in_sum;
    assign prod_d_next = gd_s * in_delta;

    assign raw_next = RAW_W'(prod_p_reg) + RAW_W'(prod_i_reg) + RAW_W'(prod_d_reg);

    assign lim_pos = RAW_W'($signed({1'b0, cfg.turn_limit}));
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (raw_reg > lim_pos)
        begin
            out_turn = lim_pos[TURN_W-1:0];
        end
        else if (raw_reg < lim_neg)
        begin
            out_turn = lim_neg[TURN_W-1:0];
        end
        else
        begin
            out_turn = raw_reg[TURN_W-1:0];
        end
    end

    assign out_valid = s_valid_reg;
    assign out_err   = s_err_reg;
    assign out_left  = $signed({2'b00, cfg.base_speed}) + TGT_W'(out_turn);
    assign out_right = $signed({2'b00, cfg.base_speed}) - TGT_W'(out_turn);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid && in_ready;
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_err_reg  <= in_err;
        prod_p_reg <= prod_p_next;
        prod_i_reg <= prod_i_next;
        prod_d_reg <= prod_d_next;
        s_err_reg  <= p_err_reg;
        raw_reg    <= raw_next;
    end

endmodule

`default_nettype wire

/* rtl/line_sensor_pid_steering_core.sv */
// Top level of the line-sensor PID steering core: configuration registers,
// front and back halves and the queues between them. Depends on lsps_pkg.
//
// One control tick per clock cycle is accepted while full is low, and one result
// per cycle is delivered while results wait and pop is high. A tick is decoded and
// folded into the error sum as it is accepted, waits in a two-entry queue, passes
// two back stages (gain products, then their sum) and the clamp and wheel targets,
// and lands in an eight-entry result queue. The back half takes a tick only when
// the result queue has room for everything in flight, so full rises once both
// queues fill while results are not popped. Configuration writes are always ready
// and take effect in the next cycle.
`default_nettype none

module line_sensor_pid_steering_core #(
    parameter int SUM_BITS = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic [7:0]                            sensor_bits,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic signed [lsps_pkg::ERR_W-1:0]          track_error,
    output logic signed [lsps_pkg::TURN_W-1:0]         turn,
    output logic signed [lsps_pkg::TGT_W-1:0]          left_target,
    output logic signed [lsps_pkg::TGT_W-1:0]          right_target,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lsps_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [lsps_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import lsps_pkg::*;

    localparam int MID_W = ERR_W + SUM_BITS + DELTA_W;
    localparam int OUT_W = ERR_W + TURN_W + 2 * TGT_W;

    cfg_t cfg_reg;

    logic                       accept;
    logic signed [ERR_W-1:0]    f_err;
    logic signed [SUM_BITS-1:0] f_sum;
    logic signed [DELTA_W-1:0]  f_delta;
    logic [MID_W-1:0]           mid_rdata;
    logic                       mid_empty;
    logic [$clog2(MID_DEPTH):0] mid_count;
    logic                       b_ready;
    logic [OUT_CNT_W-1:0]       out_count;
    logic                       b_valid;
    logic signed [ERR_W-1:0]    b_err;
    logic signed [TURN_W-1:0]   b_turn;
    logic signed [TGT_W-1:0]    b_left;
    logic signed [TGT_W-1:0]    b_right;
    logic                       out_full;
    logic [OUT_W-1:0]           out_rdata;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed <= RST_BASE_SPEED;
            cfg_reg.gain_p     <= RST_GAIN_P;
            cfg_reg.gain_i     <= RST_GAIN_I;
            cfg_reg.gain_d     <= RST_GAIN_D;
            cfg_reg.turn_limit <= RST_TURN_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_SPEED: cfg_reg.base_speed <= cfg_data;
                REG_GAIN_P:     cfg_reg.gain_p     <= cfg_data;
                REG_GAIN_I:     cfg_reg.gain_i     <= cfg_data;
                REG_GAIN_D:     cfg_reg.gain_d     <= cfg_data;
                REG_TURN_LIMIT: cfg_reg.turn_limit <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    lsps_front #(
        .SUM_BITS (SUM_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sensor_bits (sensor_bits),
        .err         (f_err),
        .sum         (f_sum),
        .delta       (f_delta)
    );

    lsps_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata ({f_err, f_sum, f_delta}),
        .full  (full),
        .pop   (b_ready),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .count (mid_count)
    );

    lsps_back #(
        .SUM_BITS (SUM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (!mid_empty && (mid_count != '0)),
        .in_ready  (b_ready),
        .in_err    (mid_rdata[MID_W-1 -: ERR_W]),
        .in_sum    (mid_rdata[DELTA_W +: SUM_BITS]),
        .in_delta  (mid_rdata[DELTA_W-1:0]),
        .out_count (out_count),
        .out_valid (b_valid),
        .out_err   (b_err),
        .out_turn  (b_turn),
        .out_left  (b_left),
        .out_right (b_right)
    );

    lsps_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b_valid && !out_full),
        .wdata ({b_err, b_turn, b_left, b_right}),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .count (out_count)
    );

    assign track_error  = out_rdata[OUT_W-1 -: ERR_W];
    assign turn         = out_rdata[2*TGT_W +: TURN_W];
    assign left_target  = out_rdata[TGT_W +: TGT_W];
    assign right_target = out_rdata[TGT_W-1:0];

endmodule

`default_nettype wire

/* rtl/lsps_checker.sv */
// Port-level checks on the line-sensor PID steering core, and the bind that
// attaches them to the top level. Depends on lsps_pkg for field widths.
`default_nettype none

module lsps_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                empty,
    input  wire logic                                pop,
    input  wire logic                                cfg_ready,
    input  wire logic signed [lsps_pkg::ERR_W-1:0]   track_error,
    input  wire logic signed [lsps_pkg::TURN_W-1:0]  turn,
    input  wire logic signed [lsps_pkg::TGT_W-1:0]   left_target,
    input  wire logic signed [lsps_pkg::TGT_W-1:0]   right_target
);

    // The two wheel targets always differ by exactly twice the turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (({left_target[9], left_target} - {right_target[9], right_target})
                    == {turn[8], turn, 1'b0}))
        else $error("wheel targets do not differ by twice the turn");

    // The decoded error never reaches the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (track_error != 5'b10000))
        else $error("track error out of range");

    // A waiting result that is not popped stays in place unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(track_error) && $stable(turn)
                              && $stable(left_target) && $stable(right_target)))
        else $error("waiting result changed before its transfer");

    // The configuration channel never refuses a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind line_sensor_pid_steering_core lsps_checker u_lsps_checker (.*);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for line_sensor_pid_steering_core: drives sensor ticks and register
// writes, predicts every result in place, and checks each popped result. Depends on lsps_pkg.
module tb;
    import lsps_pkg::*;

    // A narrow error sum lets integral saturation be reached in a few hundred ticks.
    localparam int SUM_BITS       = 12;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int PHASE_TICKS    = 165;
    localparam int NUM_PHASES     = 10;

    typedef struct packed {
        logic signed [ERR_W-1:0]  track_error;
        logic signed [TURN_W-1:0] turn;
        logic signed [TGT_W-1:0]  left_target;
        logic signed [TGT_W-1:0]  right_target;
    } steer_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [7:0]                     sensor_bits = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic signed [ERR_W-1:0]        track_error;
    logic signed [TURN_W-1:0]       turn;
    logic signed [TGT_W-1:0]        left_target;
    logic signed [TGT_W-1:0]        right_target;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_INDEX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_data = '0;

    logic [7:0]      pending_ticks [$];
    steer_result_t   expected_steer [$];
    int              fail_count = 0;
    int              cycle_count = 0;

    logic [7:0]      base_speed = RST_BASE_SPEED;
    logic [7:0]      gain_p = RST_GAIN_P;
    logic [7:0]      gain_i = RST_GAIN_I;
    logic [7:0]      gain_d = RST_GAIN_D;
    logic [7:0]      turn_limit = RST_TURN_LIMIT;
    longint          err_sum = 0;
    longint          prev_err = 0;

    int              gap_left = 0;
    int              burst_left = 1;
    int              stall_mode = 0;
    int              stall_left = 0;

    line_sensor_pid_steering_core #(
        .SUM_BITS(SUM_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .sensor_bits(sensor_bits),
        .empty(empty),
        .pop(pop),
        .track_error(track_error),
        .turn(turn),
        .left_target(left_target),
        .right_target(right_target),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_failure(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    function automatic longint line_error(input logic [7:0] bits);
        longint e;
        casez (bits)
            8'b00000111: e = -15;
            8'b11100000: e = 15;
            8'b00????00: e = 0;
            8'b11101111: e = -1;
            8'b11001111: e = -2;
            8'b10011111: e = -8;
            8'b01111111: e = -10;
            8'b11110111: e = 1;
            8'b11110011: e = 2;
            8'b11111001: e = 8;
            8'b11111110: e = 10;
            8'b11100111: e = 0;
            default:     e = 0;
        endcase
        return e;
    endfunction

    function automatic steer_result_t steer_predict(input logic [7:0] bits);
        steer_result_t res;
        longint        e;
        longint        sum_max;
        longint        raw;
        longint        lim;
        longint        t;
        longint        left;
        longint        right;
        sum_max = (longint'(1) <<< (SUM_BITS - 1)) - 1;
        e = line_error(bits);
        err_sum = err_sum + e;
        if (err_sum > sum_max)
            err_sum = sum_max;
        else if (err_sum < -sum_max - 1)
            err_sum = -sum_max - 1;
        raw = longint'(gain_p) * e + longint'(gain_i) * err_sum + longint'(gain_d) * (e - prev_err);
        prev_err = e;
        lim = longint'(turn_limit);
        t = (raw > lim) ? lim : ((raw < -lim) ? -lim : raw);
        left = longint'(base_speed) + t;
        right = longint'(base_speed) - t;
        res.track_error = e[ERR_W-1:0];
        res.turn = t[TURN_W-1:0];
        res.left_target = left[TGT_W-1:0];
        res.right_target = right[TGT_W-1:0];
        return res;
    endfunction

    function automatic logic [7:0] line_pattern(input int k);
        logic [7:0] bits;
        case (k)
            0:       bits = 8'h07;
            1:       bits = 8'hE0;
            2:       bits = {2'b00, 4'($urandom_range(0, 15)), 2'b00};
            3:       bits = 8'hEF;
            4:       bits = 8'hCF;
            5:       bits = 8'h9F;
            6:       bits = 8'h7F;
            7:       bits = 8'hF7;
            8:       bits = 8'hF3;
            9:       bits = 8'hF9;
            10:      bits = 8'hFE;
            default: bits = 8'hE7;
        endcase
        return bits;
    endfunction

    always @(posedge clk)
    begin : tick_accept
        if (rst_n && push && !full)
        begin
            expected_steer.push_back(steer_predict(sensor_bits));
            void'(pending_ticks.pop_front());
        end
    end

    always @(negedge clk)
    begin : tick_driver
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            push <= 1'b0;
            gap_left--;
        end
        else if (pending_ticks.size() > 0)
        begin
            push <= 1'b1;
            sensor_bits <= pending_ticks[0];
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
            else
            begin
                burst_left--;
            end
        end
        else
        begin
            push <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : result_stall
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 64);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= ($urandom_range(0, 3) == 0);
                default: pop <= (stall_left % 16 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_monitor
        steer_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_steer.size() == 0)
            begin
                report_failure($sformatf("result with no tick waiting: error %0d turn %0d",
                                         track_error, turn));
            end
            else
            begin
                want = expected_steer.pop_front();
                if (track_error !== want.track_error)
                    report_failure($sformatf("track_error got %0d expected %0d",
                                             track_error, want.track_error));
                if (turn !== want.turn)
                    report_failure($sformatf("turn got %0d expected %0d", turn, want.turn));
                if (left_target !== want.left_target)
                    report_failure($sformatf("left_target got %0d expected %0d",
                                             left_target, want.left_target));
                if (right_target !== want.right_target)
                    report_failure($sformatf("right_target got %0d expected %0d",
                                             right_target, want.right_target));
            end
        end
    end

    task automatic write_register(input logic [7:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_BASE_SPEED: base_speed = value;
            REG_GAIN_P:     gain_p = value;
            REG_GAIN_I:     gain_i = value;
            REG_GAIN_D:     gain_d = value;
            REG_TURN_LIMIT: turn_limit = value;
            default:        ;
        endcase
    endtask

    task automatic load_settings(input logic [7:0] base, input logic [7:0] kp,
                                 input logic [7:0] ki, input logic [7:0] kd,
                                 input logic [7:0] lim);
        write_register(8'($urandom_range(255, int'(REG_TURN_LIMIT) + 1)),
                       8'($urandom_range(0, 255)));
        write_register(REG_BASE_SPEED, base);
        write_register(REG_GAIN_P, kp);
        write_register(REG_GAIN_I, ki);
        write_register(REG_GAIN_D, kd);
        write_register(REG_TURN_LIMIT, lim);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || expected_steer.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random_ticks(input int count);
        int left;
        int run_len;
        int sel;
        int k;
        logic [7:0] bits;
        left = count;
        while (left > 0)
        begin
            sel = $urandom_range(0, 999);
            k = $urandom_range(0, 11);
            if (sel < 15)
            begin
                run_len = $urandom_range(140, 300);
                k = $urandom_range(0, 1);
            end
            else if (sel < 600)
            begin
                run_len = $urandom_range(1, 8);
            end
            else
            begin
                run_len = $urandom_range(1, 4);
            end
            if (run_len > left)
                run_len = left;
            for (int i = 0; i < run_len; i++)
            begin
                bits = (sel < 600) ? line_pattern(k) : 8'($urandom_range(0, 255));
                pending_ticks.push_back(bits);
            end
            left -= run_len;
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] directed [$];
        int         waited;
        directed = '{8'h00, 8'hFF, 8'h07, 8'hE0, 8'h3C, 8'h18, 8'hEF, 8'hCF, 8'h9F, 8'h7F,
                     8'hF7, 8'hF3, 8'hF9, 8'hFE, 8'hE7, 8'hC3, 8'h55, 8'hAA, 8'h01, 8'h80,
                     8'h07, 8'h07, 8'hE0, 8'hE0};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        foreach (directed[i])
            pending_ticks.push_back(directed[i]);
        wait_drained();

        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            case (phase)
                1:       load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                2:       load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                3:       load_settings(8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
                4:       load_settings(8'd255, 8'd255, 8'd0, 8'd255, 8'd255);
                5:       load_settings(8'd128, 8'd17, 8'd3, 8'd40, 8'd0);
                default: load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)));
            endcase
            // The sender holds off mid-phase until every outstanding result has been popped.
            queue_random_ticks(PHASE_TICKS / 2);
            wait_drained();
            queue_random_ticks(PHASE_TICKS - PHASE_TICKS / 2);
            wait_drained();
        end

        while (pending_ticks.size() != 0)
            @(posedge clk);
        waited = 0;
        while (expected_steer.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_steer.size() != 0)
            report_failure($sformatf("%0d results never arrived", expected_steer.size()));

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

endmodule
